FILE: rtl/mws_pkg.sv
// Shared types, constants and the microcode table of the mecanum wheel speed limiter.
// Depends on nothing; used by mws_seq, mws_datapath and mecanum_wheel_speed_limiter.
package mws_pkg;

    // Reduction limit and fixed-point constants (factor in Q2.30)
    localparam int                 MAX_REDUCTIONS = 30;
    localparam logic        [31:0] STEP_Q30       = 32'd35791466;
    localparam logic        [31:0] ONE_Q30        = 32'h4000_0000;
    localparam logic signed [63:0] HALF_Q30       = 64'sh0000_0000_2000_0000;
    localparam logic        [63:0] HALF_Q32       = 64'h0000_0000_8000_0000;

    // Configuration register indexes
    localparam logic [1:0] CFG_GEOMETRY   = 2'd0;
    localparam logic [1:0] CFG_INV_RADIUS = 2'd1;
    localparam logic [1:0] CFG_MAX_SPEED  = 2'd2;

    // Register reset values
    localparam logic [15:0] RST_GEOMETRY   = 16'd19661;
    localparam logic [15:0] RST_INV_RADIUS = 16'd5120;
    localparam logic [14:0] RST_MAX_SPEED  = 15'd300;

    // Program layout
    localparam int                PROG_LEN = 28;
    localparam int                PC_W     = $clog2(PROG_LEN);
    localparam logic [PC_W-1:0]   ST_PASS  = PC_W'(0);
    localparam logic [PC_W-1:0]   ST_ZERO  = PC_W'(26);
    localparam logic [PC_W-1:0]   ST_DONE  = PC_W'(27);

    // Reduction count wide enough for any limit up to 63
    typedef logic [5:0] t_rcnt;

    typedef enum logic [2:0] {
        A_NONE, A_MAGX, A_MAGY, A_MAGZ, A_SZ, A_WLO, A_WHI, A_F
    } t_asel;

    typedef enum logic [2:0] {
        B_NONE, B_FLO, B_FHI, B_G, B_R, B_SLO, B_SHI
    } t_bsel;

    typedef enum logic [1:0] {
        SH_0, SH_16, SH_20
    } t_shsel;

    typedef enum logic [1:0] {
        ACC_HOLD, ACC_CLR, ACC_RND, ACC_ADD
    } t_accop;

    typedef enum logic [3:0] {
        DST_NONE, DST_SX, DST_SY, DST_SZ, DST_C, DST_MAG,
        DST_OUT0, DST_OUT1, DST_OUT2, DST_OUT3,
        DST_F, DST_INC, DST_ZERO, DST_DONE
    } t_dst;

    typedef enum logic [2:0] {
        W_NONE, W_1, W_2, W_3, W_4
    } t_wsel;

    typedef enum logic [1:0] {
        JMP_NEXT, JMP_FIT, JMP_LIMIT, JMP_ALWAYS
    } t_jmp;

    // One control word per program step
    typedef struct packed {
        t_asel           a_sel;
        t_bsel           b_sel;
        t_shsel          sh;
        t_accop          acc_op;
        t_dst            dst;
        t_wsel           w_sel;
        logic            fit_clr;
        t_jmp            jmp;
        logic [PC_W-1:0] target;
    } t_ctrl;

    // Datapath flags seen by the sequencer
    typedef struct packed {
        logic fit;
        logic at_limit;
    } t_stat;

    // Microcode table: one pass computes all four wheels, then branch/reduce
    function automatic t_ctrl ucode(input logic [PC_W-1:0] pc);
        t_ctrl c;
        c = '0;
        case (pc)
            // scale vx by the factor, rounded
            5'd0: begin
                c.a_sel = A_MAGX; c.b_sel = B_FLO; c.acc_op = ACC_RND; c.fit_clr = 1'b1;
            end
            5'd1: begin
                c.a_sel = A_MAGX; c.b_sel = B_FHI; c.sh = SH_16; c.acc_op = ACC_ADD;
            end
            // scale vy
            5'd2: begin
                c.a_sel = A_MAGY; c.b_sel = B_FLO; c.acc_op = ACC_RND; c.dst = DST_SX;
            end
            5'd3: begin
                c.a_sel = A_MAGY; c.b_sel = B_FHI; c.sh = SH_16; c.acc_op = ACC_ADD;
            end
            // scale wz
            5'd4: begin
                c.a_sel = A_MAGZ; c.b_sel = B_FLO; c.acc_op = ACC_RND; c.dst = DST_SY;
            end
            5'd5: begin
                c.a_sel = A_MAGZ; c.b_sel = B_FHI; c.sh = SH_16; c.acc_op = ACC_ADD;
            end
            5'd6: begin
                c.dst = DST_SZ;
            end
            // geometry term
            5'd7: begin
                c.a_sel = A_SZ; c.b_sel = B_G; c.acc_op = ACC_CLR;
            end
            5'd8: begin
                c.dst = DST_C;
            end
            5'd9: begin
                c.w_sel = W_1;
            end
            // wheel products, interleaved with magnitude and output steps
            5'd10: begin
                c.a_sel = A_WLO; c.b_sel = B_R; c.acc_op = ACC_CLR;
            end
            5'd11: begin
                c.a_sel = A_WHI; c.b_sel = B_R; c.sh = SH_20; c.acc_op = ACC_ADD;
                c.w_sel = W_2;
            end
            5'd12: begin
                c.a_sel = A_WLO; c.b_sel = B_R; c.acc_op = ACC_CLR; c.dst = DST_MAG;
            end
            5'd13: begin
                c.a_sel = A_WHI; c.b_sel = B_R; c.sh = SH_20; c.acc_op = ACC_ADD;
                c.w_sel = W_3; c.dst = DST_OUT0;
            end
            5'd14: begin
                c.a_sel = A_WLO; c.b_sel = B_R; c.acc_op = ACC_CLR; c.dst = DST_MAG;
            end
            5'd15: begin
                c.a_sel = A_WHI; c.b_sel = B_R; c.sh = SH_20; c.acc_op = ACC_ADD;
                c.w_sel = W_4; c.dst = DST_OUT1;
            end
            5'd16: begin
                c.a_sel = A_WLO; c.b_sel = B_R; c.acc_op = ACC_CLR; c.dst = DST_MAG;
            end
            5'd17: begin
                c.a_sel = A_WHI; c.b_sel = B_R; c.sh = SH_20; c.acc_op = ACC_ADD;
                c.dst = DST_OUT2;
            end
            5'd18: begin
                c.dst = DST_MAG;
            end
            5'd19: begin
                c.dst = DST_OUT3;
            end
            // branch on the fit test and the reduction limit
            5'd20: begin
                c.jmp = JMP_FIT; c.target = ST_DONE;
            end
            5'd21: begin
                c.jmp = JMP_LIMIT; c.target = ST_ZERO;
            end
            // next reduction: count, step, compound the factor
            5'd22: begin
                c.dst = DST_INC;
            end
            5'd23: begin
                c.a_sel = A_F; c.b_sel = B_SLO; c.acc_op = ACC_RND;
            end
            5'd24: begin
                c.a_sel = A_F; c.b_sel = B_SHI; c.sh = SH_16; c.acc_op = ACC_ADD;
            end
            5'd25: begin
                c.dst = DST_F; c.jmp = JMP_ALWAYS; c.target = ST_PASS;
            end
            5'd26: begin
                c.dst = DST_ZERO;
            end
            5'd27: begin
                c.dst = DST_DONE;
            end
            default: begin
                c.dst = DST_DONE;
            end
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/mecanum_wheel_speed_limiter.sv
// Top level of the mecanum wheel speed limiter: configuration registers,
// start handshake, sequencer and datapath. Depends on mws_pkg, mws_seq, mws_datapath.
//
// Usage:
//  - Command channel: drive i_velocity_x, i_velocity_y, i_yaw_rate (signed Q4.12)
//    and pulse start; the command transfers at a rising edge with start high
//    and busy low. busy stays high until the result is produced.
//  - Result channel: o_valid is high for exactly one cycle with the four wheel
//    speeds (1/16 units, saturated) and the number of scale-down steps. The
//    receiver cannot stall; results are held until the next result replaces them.
//  - Configuration: write geometry_sum, inverse_wheel_radius, max_wheel_speed
//    through i_cfg_we / i_cfg_idx / i_cfg_data while busy is low; unknown
//    indexes are ignored.
//  - Timing: one microcoded pass per factor tried, on a single shared
//    32x16 multiplier; at most 30 reductions, after which a failing fit
//    forces zero speeds. One command in flight at a time; a new command
//    can transfer in the same cycle as the strobe.
//  - Reset: synchronous active-low; restores register defaults and idles.
module mecanum_wheel_speed_limiter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_velocity_x,
    input  logic signed [15:0] i_velocity_y,
    input  logic signed [15:0] i_yaw_rate,
    input  logic               i_cfg_we,
    input  logic        [1:0]  i_cfg_idx,
    input  logic        [15:0] i_cfg_data,
    output logic               o_valid,
    output logic signed [19:0] o_speed_front_right,
    output logic signed [19:0] o_speed_front_left,
    output logic signed [19:0] o_speed_back_left,
    output logic signed [19:0] o_speed_back_right,
    output logic        [4:0]  o_reductions_applied
);

    logic [15:0]    r_geometry_sum;
    logic [15:0]    r_inverse_wheel_radius;
    logic [14:0]    r_max_wheel_speed;
    logic           accept;
    mws_pkg::t_ctrl ctrl;
    mws_pkg::t_stat stat;

    // Command transfer
    assign accept = start && !busy;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geometry_sum         <= mws_pkg::RST_GEOMETRY;
            r_inverse_wheel_radius <= mws_pkg::RST_INV_RADIUS;
            r_max_wheel_speed      <= mws_pkg::RST_MAX_SPEED;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mws_pkg::CFG_GEOMETRY:   r_geometry_sum         <= i_cfg_data;
                mws_pkg::CFG_INV_RADIUS: r_inverse_wheel_radius <= i_cfg_data;
                mws_pkg::CFG_MAX_SPEED:  r_max_wheel_speed      <= i_cfg_data[14:0];
                default: begin
                end
            endcase
        end
    end

    // Program sequencer
    mws_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_stat   (stat),
        .o_ctrl   (ctrl),
        .o_busy   (busy),
        .o_valid  (o_valid)
    );

    // Arithmetic datapath
    mws_datapath u_datapath (
        .i_clk                  (i_clk),
        .i_load                 (accept),
        .i_velocity_x           (i_velocity_x),
        .i_velocity_y           (i_velocity_y),
        .i_yaw_rate             (i_yaw_rate),
        .i_geometry_sum         (r_geometry_sum),
        .i_inverse_wheel_radius (r_inverse_wheel_radius),
        .i_max_wheel_speed      (r_max_wheel_speed),
        .i_ctrl                 (ctrl),
        .o_stat                 (stat),
        .o_speed_front_right    (o_speed_front_right),
        .o_speed_front_left     (o_speed_front_left),
        .o_speed_back_left      (o_speed_back_left),
        .o_speed_back_right     (o_speed_back_right),
        .o_reductions_applied   (o_reductions_applied)
    );

endmodule

FILE: rtl/mws_seq.sv
// Step counter and program sequencer of the mecanum wheel speed limiter.
// Depends on mws_pkg (control word, status flags, microcode table).
module mws_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  mws_pkg::t_stat i_stat,
    output mws_pkg::t_ctrl o_ctrl,
    output logic           o_busy,
    output logic           o_valid
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state                    r_state;
    logic [mws_pkg::PC_W-1:0]  r_pc;
    logic [mws_pkg::PC_W-1:0]  n_pc;
    logic                      r_valid;
    mws_pkg::t_ctrl            rom_word;
    logic                      taken;

    // Fetch the control word for the current step
    always_comb begin
        rom_word = mws_pkg::ucode(r_pc);
    end

    // Resolve the conditional jump
    always_comb begin
        case (rom_word.jmp)
            mws_pkg::JMP_FIT:    taken = i_stat.fit;
            mws_pkg::JMP_LIMIT:  taken = i_stat.at_limit;
            mws_pkg::JMP_ALWAYS: taken = 1'b1;
            default:             taken = 1'b0;
        endcase
        n_pc = taken ? rom_word.target : r_pc + mws_pkg::PC_W'(1);
    end

    // Hold state, step counter and the result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= mws_pkg::ST_PASS;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_accept) begin
                        r_state <= S_RUN;
                        r_pc    <= mws_pkg::ST_PASS;
                    end
                end
                S_RUN: begin
                    if (rom_word.dst == mws_pkg::DST_DONE) begin
                        r_state <= S_IDLE;
                        r_valid <= 1'b1;
                    end else begin
                        r_pc <= n_pc;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Idle cycles drive a no-op word
    assign o_ctrl  = (r_state == S_RUN) ? rom_word : '0;
    assign o_busy  = (r_state == S_RUN);
    assign o_valid = r_valid;

endmodule

FILE: rtl/mws_datapath.sv
// Datapath of the mecanum wheel speed limiter: one shared 32x16 multiplier,
// a 64-bit accumulator and the working registers. Depends on mws_pkg.
module mws_datapath (
    input  logic                i_clk,
    input  logic                i_load,
    input  logic signed [15:0]  i_velocity_x,
    input  logic signed [15:0]  i_velocity_y,
    input  logic signed [15:0]  i_yaw_rate,
    input  logic        [15:0]  i_geometry_sum,
    input  logic        [15:0]  i_inverse_wheel_radius,
    input  logic        [14:0]  i_max_wheel_speed,
    input  mws_pkg::t_ctrl      i_ctrl,
    output mws_pkg::t_stat      o_stat,
    output logic signed [19:0]  o_speed_front_right,
    output logic signed [19:0]  o_speed_front_left,
    output logic signed [19:0]  o_speed_back_left,
    output logic signed [19:0]  o_speed_back_right,
    output logic        [4:0]   o_reductions_applied
);

    // Command magnitudes times 60 and their signs
    logic        [20:0] r_vmag [3];
    logic        [2:0]  r_vneg;
    // Factor, accumulated step, reduction count
    logic        [30:0] r_f;
    logic        [31:0] r_d;
    mws_pkg::t_rcnt     r_k;
    // Scaled components, geometry term, wheel sum
    logic signed [21:0] r_sx;
    logic signed [21:0] r_sy;
    logic signed [21:0] r_sz;
    logic signed [37:0] r_c;
    logic signed [39:0] r_w;
    // Accumulator, product magnitude and sign
    logic signed [63:0] r_acc;
    logic signed [63:0] n_acc;
    logic        [63:0] r_mag;
    logic               r_pneg;
    logic               r_fail;
    logic signed [19:0] r_res [4];
    logic signed [19:0] r_out [4];
    logic        [4:0]  r_cnt_out;

    logic        [15:0] in_mag [3];
    logic        [2:0]  in_neg;
    logic signed [31:0] mul_a;
    logic        [15:0] mul_b;
    logic signed [48:0] prod;
    logic signed [63:0] prod_ext;
    logic signed [63:0] prod_sh;
    logic        [30:0] s_k;
    logic        [21:0] sc_pos;
    logic        [21:0] sc_neg;
    logic signed [39:0] wa;
    logic signed [39:0] wb;
    logic signed [39:0] wc;
    logic signed [39:0] w_next;
    logic        [63:0] lim;
    logic               over;
    logic        [63:0] rsum;
    logic        [31:0] rmag;
    logic signed [19:0] res_val;

    // Input magnitudes and signs
    always_comb begin
        in_neg    = {i_yaw_rate[15], i_velocity_y[15], i_velocity_x[15]};
        in_mag[0] = i_velocity_x[15] ? 16'(-i_velocity_x) : i_velocity_x;
        in_mag[1] = i_velocity_y[15] ? 16'(-i_velocity_y) : i_velocity_y;
        in_mag[2] = i_yaw_rate[15]   ? 16'(-i_yaw_rate)   : i_yaw_rate;
    end

    // Reduction step factor s = 1 - k*step, floored at zero
    assign s_k = (r_d >= mws_pkg::ONE_Q30) ? '0 : 31'(mws_pkg::ONE_Q30 - r_d);

    // Select multiplier operands
    always_comb begin
        case (i_ctrl.a_sel)
            mws_pkg::A_MAGX: mul_a = {11'b0, r_vmag[0]};
            mws_pkg::A_MAGY: mul_a = {11'b0, r_vmag[1]};
            mws_pkg::A_MAGZ: mul_a = {11'b0, r_vmag[2]};
            mws_pkg::A_SZ:   mul_a = {{10{r_sz[21]}}, r_sz};
            mws_pkg::A_WLO:  mul_a = {12'b0, r_w[19:0]};
            mws_pkg::A_WHI:  mul_a = {{12{r_w[39]}}, r_w[39:20]};
            mws_pkg::A_F:    mul_a = {1'b0, r_f};
            default:         mul_a = '0;
        endcase
        case (i_ctrl.b_sel)
            mws_pkg::B_FLO: mul_b = r_f[15:0];
            mws_pkg::B_FHI: mul_b = {1'b0, r_f[30:16]};
            mws_pkg::B_G:   mul_b = i_geometry_sum;
            mws_pkg::B_R:   mul_b = i_inverse_wheel_radius;
            mws_pkg::B_SLO: mul_b = s_k[15:0];
            mws_pkg::B_SHI: mul_b = {1'b0, s_k[30:16]};
            default:        mul_b = '0;
        endcase
    end

    // Multiply, align and accumulate
    assign prod     = mul_a * $signed({1'b0, mul_b});
    assign prod_ext = 64'(prod);

    always_comb begin
        case (i_ctrl.sh)
            mws_pkg::SH_16: prod_sh = prod_ext <<< 16;
            mws_pkg::SH_20: prod_sh = prod_ext <<< 20;
            default:        prod_sh = prod_ext;
        endcase
        case (i_ctrl.acc_op)
            mws_pkg::ACC_CLR: n_acc = prod_sh;
            mws_pkg::ACC_RND: n_acc = prod_sh + mws_pkg::HALF_Q30;
            mws_pkg::ACC_ADD: n_acc = r_acc + prod_sh;
            default:          n_acc = r_acc;
        endcase
    end

    // Rounded scaled magnitude and its negation
    assign sc_pos = {1'b0, r_acc[50:30]};
    assign sc_neg = ~sc_pos + 22'd1;

    // Wheel sums from the scaled components
    always_comb begin
        wa = {{2{r_sx[21]}}, r_sx, 16'b0};
        wb = {{2{r_sy[21]}}, r_sy, 16'b0};
        wc = {{2{r_c[37]}}, r_c};
        case (i_ctrl.w_sel)
            mws_pkg::W_1: w_next = wa + wb + wc;
            mws_pkg::W_2: w_next = wa - wb - wc;
            mws_pkg::W_3: w_next = wa + wb - wc;
            mws_pkg::W_4: w_next = wa - wb + wc;
            default:      w_next = r_w;
        endcase
    end

    // Fit test, round and saturate one wheel product
    always_comb begin
        lim  = {13'b0, i_max_wheel_speed, 36'b0};
        over = (r_mag > lim);
        rsum = r_mag + mws_pkg::HALF_Q32;
        rmag = rsum[63:32];
        if (r_pneg) begin
            res_val = (rmag > 32'd524288) ? 20'sh80000 : 20'(-$signed({1'b0, rmag}));
        end else begin
            res_val = (rmag > 32'd524287) ? 20'sh7FFFF : 20'(rmag);
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_w   <= w_next;
        if (i_ctrl.fit_clr) begin
            r_fail <= 1'b0;
        end
        if (i_load) begin
            r_vmag[0] <= (21'(in_mag[0]) << 6) - (21'(in_mag[0]) << 2);
            r_vmag[1] <= (21'(in_mag[1]) << 6) - (21'(in_mag[1]) << 2);
            r_vmag[2] <= (21'(in_mag[2]) << 6) - (21'(in_mag[2]) << 2);
            r_vneg    <= in_neg;
            r_f       <= mws_pkg::ONE_Q30[30:0];
            r_d       <= '0;
            r_k       <= '0;
        end
        case (i_ctrl.dst)
            mws_pkg::DST_SX:  r_sx <= r_vneg[0] ? sc_neg : sc_pos;
            mws_pkg::DST_SY:  r_sy <= r_vneg[1] ? sc_neg : sc_pos;
            mws_pkg::DST_SZ:  r_sz <= r_vneg[2] ? sc_neg : sc_pos;
            mws_pkg::DST_C:   r_c  <= r_acc[37:0];
            mws_pkg::DST_MAG: begin
                r_mag  <= r_acc[63] ? 64'(-r_acc) : 64'(r_acc);
                r_pneg <= r_acc[63];
            end
            mws_pkg::DST_OUT0: begin
                r_res[0] <= res_val;
                r_fail   <= r_fail | over;
            end
            mws_pkg::DST_OUT1: begin
                r_res[1] <= res_val;
                r_fail   <= r_fail | over;
            end
            mws_pkg::DST_OUT2: begin
                r_res[2] <= res_val;
                r_fail   <= r_fail | over;
            end
            mws_pkg::DST_OUT3: begin
                r_res[3] <= res_val;
                r_fail   <= r_fail | over;
            end
            mws_pkg::DST_F:   r_f <= r_acc[60:30];
            mws_pkg::DST_INC: begin
                r_k <= r_k + 6'd1;
                r_d <= r_d + mws_pkg::STEP_Q30;
            end
            mws_pkg::DST_ZERO: begin
                r_res[0] <= '0;
                r_res[1] <= '0;
                r_res[2] <= '0;
                r_res[3] <= '0;
            end
            mws_pkg::DST_DONE: begin
                r_out[0]  <= r_res[0];
                r_out[1]  <= r_res[1];
                r_out[2]  <= r_res[2];
                r_out[3]  <= r_res[3];
                r_cnt_out <= (r_k > 6'd31) ? 5'd31 : r_k[4:0];
            end
            default: begin
            end
        endcase
    end

    assign o_stat.fit      = !r_fail;
    assign o_stat.at_limit = (r_k >= 6'(mws_pkg::MAX_REDUCTIONS));

    assign o_speed_front_right  = r_out[0];
    assign o_speed_front_left   = r_out[1];
    assign o_speed_back_left    = r_out[2];
    assign o_speed_back_right   = r_out[3];
    assign o_reductions_applied = r_cnt_out;

endmodule

FILE: sim/mecanum_wheel_speed_limiter_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for mecanum_wheel_speed_limiter: directed table, then random phases.
// Depends on mws_pkg and the RTL top level; wheel speeds are predicted in-bench.
module mecanum_wheel_speed_limiter_tb;

    // Factor arithmetic in Q2.30, output rounding at 2^32
    localparam longint unsigned FACTOR_ONE  = 64'd1073741824;
    localparam longint unsigned FACTOR_HALF = 64'd536870912;
    localparam longint unsigned FACTOR_STEP = 64'd35791466;
    localparam longint unsigned OUT_HALF    = 64'd2147483648;
    localparam longint          SPEED_HI    = 524287;
    localparam longint          SPEED_LO    = -524288;
    localparam logic [1:0]      CFG_GEOMETRY   = mws_pkg::CFG_GEOMETRY;
    localparam logic [1:0]      CFG_INV_RADIUS = mws_pkg::CFG_INV_RADIUS;
    localparam logic [1:0]      CFG_MAX_SPEED  = mws_pkg::CFG_MAX_SPEED;
    localparam logic [1:0]      CFG_UNUSED  = 2'd3;
    localparam int              DRAIN_CYCLES = 850;

    typedef struct packed {
        logic signed [19:0] front_right;
        logic signed [19:0] front_left;
        logic signed [19:0] back_left;
        logic signed [19:0] back_right;
        logic        [4:0]  steps;
    } t_wheel_result;

    localparam t_wheel_result ZERO_SPEEDS = '0;

    typedef enum logic { ROW_CMD, ROW_CFG } t_row_kind;

    typedef struct packed {
        t_row_kind          kind;
        logic        [1:0]  reg_idx;
        logic        [15:0] reg_data;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] wz;
        logic               typed;
        t_wheel_result      typed_res;
    } t_stim_row;

    typedef struct packed {
        logic [15:0] geometry;
        logic [15:0] inv_radius;
        logic [15:0] max_speed;
        bit          rand_cfg;
        int          gap_pct;
        int          items;
    } t_phase;

    // Directed commands and register writes; typed results only where obvious
    localparam int DIRECTED_LEN = 25;
    localparam t_stim_row DIRECTED [DIRECTED_LEN] = '{
        '{ROW_CMD, CFG_GEOMETRY, 16'h0, 16'sh0000, 16'sh0000, 16'sh0000, 1'b1, ZERO_SPEEDS},
        '{ROW_CMD, CFG_GEOMETRY, 16'h0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0, ZERO_SPEEDS},
        '{ROW_CMD, CFG_GEOMETRY, 16'h0, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0, ZERO_SPEEDS},
        '{ROW_CMD, CFG_GEOMETRY, 16'h0, 16'sh7FFF, 16'sh8000, 16'sh0000, 1'b0, ZERO_SPEEDS},
        '{ROW_CMD, CFG_GEOMETRY, 16'h0, 16'sh0000, 16'sh0000, 16'sh8000, 1'b0, ZERO_SPEEDS},
        '{ROW_CMD, CFG_GEOMETRY, 16'h0, 16'sh0001, 16'sh0000, 16'sh0000, 1'b0, ZERO_SPEEDS},
        '{ROW_CMD, CFG_GEOMETRY, 16'h0, 16'sh1000, 16'sh0000, 16'sh0000, 1'b0, ZERO_SPEEDS},
        '{ROW_CMD, CFG_GEOMETRY, 16'h0, 16'sh0000, 16'sh1000, 16'sh0000, 1'b0, ZERO_SPEEDS},
        '{ROW_CMD, CFG_GEOMETRY, 16'h0, 16'sh0000, 16'sh0000, 16'sh1000, 1'b0, ZERO_SPEEDS},
        '{ROW_CMD, CFG_GEOMETRY, 16'h0, 16'shFFFF, 16'shFFFF, 16'shFFFF, 1'b0, ZERO_SPEEDS},
        // writes to an unmapped index must not disturb anything
        '{ROW_CFG, CFG_UNUSED, 16'hFFFF, 16'sh0, 16'sh0, 16'sh0, 1'b0, ZERO_SPEEDS},
        '{ROW_CMD, CFG_GEOMETRY, 16'h0, 16'sh0100, 16'sh0080, 16'sh0040, 1'b0, ZERO_SPEEDS},
        // zero inverse radius: every wheel at rest, no reductions
        '{ROW_CFG, CFG_INV_RADIUS, 16'h0000, 16'sh0, 16'sh0, 16'sh0, 1'b0, ZERO_SPEEDS},
        '{ROW_CMD, CFG_GEOMETRY, 16'h0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1, ZERO_SPEEDS},
        '{ROW_CMD, CFG_GEOMETRY, 16'h0, 16'sh8000, 16'sh3039, 16'shFCF7, 1'b1, ZERO_SPEEDS},
        // zero max speed: reduce until nothing moves
        '{ROW_CFG, CFG_INV_RADIUS, 16'hFFFF, 16'sh0, 16'sh0, 16'sh0, 1'b0, ZERO_SPEEDS},
        '{ROW_CFG, CFG_GEOMETRY, 16'hFFFF, 16'sh0, 16'sh0, 16'sh0, 1'b0, ZERO_SPEEDS},
        '{ROW_CFG, CFG_MAX_SPEED, 16'h0000, 16'sh0, 16'sh0, 16'sh0, 1'b0, ZERO_SPEEDS},
        '{ROW_CMD, CFG_GEOMETRY, 16'h0, 16'sh0000, 16'sh0000, 16'sh0000, 1'b1, ZERO_SPEEDS},
        '{ROW_CMD, CFG_GEOMETRY, 16'h0, 16'sh0064, 16'shFF38, 16'sh012C, 1'b0, ZERO_SPEEDS},
        // opposite extremes: no geometry term, smallest radius, widest limit
        '{ROW_CFG, CFG_GEOMETRY, 16'h0000, 16'sh0, 16'sh0, 16'sh0, 1'b0, ZERO_SPEEDS},
        '{ROW_CFG, CFG_INV_RADIUS, 16'h0001, 16'sh0, 16'sh0, 16'sh0, 1'b0, ZERO_SPEEDS},
        '{ROW_CFG, CFG_MAX_SPEED, 16'hFFFF, 16'sh0, 16'sh0, 16'sh0, 1'b0, ZERO_SPEEDS},
        '{ROW_CMD, CFG_GEOMETRY, 16'h0, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 1'b0, ZERO_SPEEDS},
        '{ROW_CMD, CFG_GEOMETRY, 16'h0, 16'sh8000, 16'sh8000, 16'sh7FFF, 1'b0, ZERO_SPEEDS}
    };

    // Random phases; the receiver cannot stall, so only the sender idles
    localparam int PHASE_CNT = 7;
    localparam t_phase PHASES [PHASE_CNT] = '{
        '{16'd19661, 16'd5120,  16'd300,   1'b0, 0,  160},
        '{16'd0,     16'd1,     16'h7FFF,  1'b0, 65, 100},
        '{16'hFFFF,  16'hFFFF,  16'd1,     1'b0, 12, 90},
        '{16'd30000, 16'd256,   16'd1000,  1'b0, 65, 120},
        '{16'd19661, 16'd5120,  16'd0,     1'b0, 0,  30},
        '{16'd1234,  16'd0,     16'd50,    1'b0, 12, 30},
        '{16'd0,     16'd0,     16'd0,     1'b1, 65, 120}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [15:0] i_velocity_x;
    logic signed [15:0] i_velocity_y;
    logic signed [15:0] i_yaw_rate;
    logic               i_cfg_we;
    logic        [1:0]  i_cfg_idx;
    logic        [15:0] i_cfg_data;
    logic               o_valid;
    logic signed [19:0] o_speed_front_right;
    logic signed [19:0] o_speed_front_left;
    logic signed [19:0] o_speed_back_left;
    logic signed [19:0] o_speed_back_right;
    logic        [4:0]  o_reductions_applied;

    // Register copies used for prediction
    logic [15:0] cfg_geometry;
    logic [15:0] cfg_inv_radius;
    logic [14:0] cfg_max_speed;

    t_wheel_result pending_speeds [$];
    int            mismatch_count;

    mecanum_wheel_speed_limiter u_top (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .start                (start),
        .busy                 (busy),
        .i_velocity_x         (i_velocity_x),
        .i_velocity_y         (i_velocity_y),
        .i_yaw_rate           (i_yaw_rate),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data),
        .o_valid              (o_valid),
        .o_speed_front_right  (o_speed_front_right),
        .o_speed_front_left   (o_speed_front_left),
        .o_speed_back_left    (o_speed_back_left),
        .o_speed_back_right   (o_speed_back_right),
        .o_reductions_applied (o_reductions_applied)
    );

    // 2 ns clock
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Component times factor / 2^30, rounded half away from zero
    function automatic longint scale_by_factor(longint comp, longint unsigned factor);
        longint unsigned mag;
        longint unsigned scaled;
        mag    = (comp < 0) ? -comp : comp;
        scaled = (mag * factor + FACTOR_HALF) >> 30;
        return (comp < 0) ? -longint'(scaled) : longint'(scaled);
    endfunction

    // Q.36 product to 1/16 output units, rounded and saturated
    function automatic logic signed [19:0] round_to_speed(longint prod);
        longint unsigned mag;
        longint          speed;
        mag = (prod < 0) ? -prod : prod;
        mag = (mag + OUT_HALF) >> 32;
        if (prod < 0) begin
            speed = (mag > 64'd524288) ? SPEED_LO : -longint'(mag);
        end else begin
            speed = (mag > 64'd524287) ? SPEED_HI : longint'(mag);
        end
        return speed[19:0];
    endfunction

    // Wheel speeds for one command under the current register values
    function automatic t_wheel_result wheel_speeds_predict(logic signed [15:0] vx,
                                                           logic signed [15:0] vy,
                                                           logic signed [15:0] wz);
        longint          cmd_x, cmd_y, cmd_z;
        longint          sx, sy, gz, radius, limit;
        longint          prod [4];
        longint unsigned factor, cut, shrink;
        int              steps;
        bit              done, fits;
        t_wheel_result   res;
        cmd_x  = longint'(vx) * 60;
        cmd_y  = longint'(vy) * 60;
        cmd_z  = longint'(wz) * 60;
        radius = longint'(cfg_inv_radius);
        limit  = longint'(cfg_max_speed) << 36;
        factor = FACTOR_ONE;
        steps  = 0;
        done   = 1'b0;
        while (!done) begin
            sx = scale_by_factor(cmd_x, factor) * 65536;
            sy = scale_by_factor(cmd_y, factor) * 65536;
            gz = scale_by_factor(cmd_z, factor) * longint'(cfg_geometry);
            prod[0] = (sx + sy + gz) * radius;
            prod[1] = (sx - sy - gz) * radius;
            prod[2] = (sx + sy - gz) * radius;
            prod[3] = (sx - sy + gz) * radius;
            fits = 1'b1;
            foreach (prod[i]) begin
                if (((prod[i] < 0) ? -prod[i] : prod[i]) > limit) fits = 1'b0;
            end
            if (fits) begin
                done = 1'b1;
            end else if (steps >= mws_pkg::MAX_REDUCTIONS) begin
                // out of reductions: stop every wheel
                foreach (prod[i]) prod[i] = 0;
                done = 1'b1;
            end else begin
                // shrink by 1 - k*step, compounding into the factor
                steps++;
                cut    = steps * FACTOR_STEP;
                shrink = (cut >= FACTOR_ONE) ? 64'd0 : FACTOR_ONE - cut;
                factor = (factor * shrink + FACTOR_HALF) >> 30;
            end
        end
        res.front_right = round_to_speed(prod[0]);
        res.front_left  = round_to_speed(prod[1]);
        res.back_left   = round_to_speed(prod[2]);
        res.back_right  = round_to_speed(prod[3]);
        res.steps       = (steps > 31) ? 5'd31 : 5'(steps);
        return res;
    endfunction

    // Command value biased toward small and mid magnitudes, full range the rest
    function automatic logic signed [15:0] rand_velocity();
        int t;
        case ($urandom_range(9))
            0:       t = 0;
            1, 2, 3: t = int'($urandom_range(1023)) - 512;
            4, 5, 6: t = int'($urandom_range(16383)) - 8192;
            default: t = int'($urandom);
        endcase
        return t[15:0];
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // Hold the command until it transfers; idle start at random per cycle
    task automatic send_command(logic signed [15:0] vx, logic signed [15:0] vy,
                                logic signed [15:0] wz, int gap_pct,
                                bit typed, t_wheel_result typed_res);
        bit go;
        bit taken;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            go = ($urandom_range(99) >= gap_pct);
            if (go) begin
                i_velocity_x = vx;
                i_velocity_y = vy;
                i_yaw_rate   = wz;
            end else begin
                i_velocity_x = 16'($urandom);
                i_velocity_y = 16'($urandom);
                i_yaw_rate   = 16'($urandom);
            end
            start = go;
            @(posedge i_clk);
            if (go && !busy) begin
                taken = 1'b1;
                pending_speeds.push_back(typed ? typed_res : wheel_speeds_predict(vx, vy, wz));
            end
        end
    endtask

    // Drop start and wait for the block to drain
    task automatic wait_idle();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_speeds.size() != 0) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        case (idx)
            CFG_GEOMETRY:   cfg_geometry   = data;
            CFG_INV_RADIUS: cfg_inv_radius = data;
            CFG_MAX_SPEED:  cfg_max_speed  = data[14:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Compare each strobed result with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_wheel_result want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_speeds.size() == 0) begin
                report_mismatch("result strobe with no command outstanding");
            end else begin
                want = pending_speeds.pop_front();
                if (o_speed_front_right !== want.front_right)
                    report_mismatch($sformatf("front right %0d, want %0d",
                                              o_speed_front_right, want.front_right));
                if (o_speed_front_left !== want.front_left)
                    report_mismatch($sformatf("front left %0d, want %0d",
                                              o_speed_front_left, want.front_left));
                if (o_speed_back_left !== want.back_left)
                    report_mismatch($sformatf("back left %0d, want %0d",
                                              o_speed_back_left, want.back_left));
                if (o_speed_back_right !== want.back_right)
                    report_mismatch($sformatf("back right %0d, want %0d",
                                              o_speed_back_right, want.back_right));
                if (o_reductions_applied !== want.steps)
                    report_mismatch($sformatf("reductions %0d, want %0d",
                                              o_reductions_applied, want.steps));
            end
        end
    end

    // Stimulus: reset, directed table, random phases, drain
    initial begin : stimulus
        int     row;
        int     ph;
        int     n;
        t_phase cur;
        mismatch_count = 0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_velocity_x   = '0;
        i_velocity_y   = '0;
        i_yaw_rate     = '0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_GEOMETRY;
        i_cfg_data     = '0;
        cfg_geometry   = mws_pkg::RST_GEOMETRY;
        cfg_inv_radius = mws_pkg::RST_INV_RADIUS;
        cfg_max_speed  = mws_pkg::RST_MAX_SPEED;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Walk the directed table
        for (row = 0; row < DIRECTED_LEN; row++) begin
            if (DIRECTED[row].kind == ROW_CFG) begin
                wait_idle();
                write_register(DIRECTED[row].reg_idx, DIRECTED[row].reg_data);
            end else begin
                send_command(DIRECTED[row].vx, DIRECTED[row].vy, DIRECTED[row].wz, 0,
                             DIRECTED[row].typed, DIRECTED[row].typed_res);
            end
        end

        // Random phases, each under its own register setting
        for (ph = 0; ph < PHASE_CNT; ph++) begin
            cur = PHASES[ph];
            wait_idle();
            if (cur.rand_cfg) begin
                write_register(CFG_UNUSED, 16'($urandom));
                write_register(CFG_GEOMETRY, 16'($urandom));
                write_register(CFG_INV_RADIUS, 16'($urandom));
                write_register(CFG_MAX_SPEED, 16'($urandom));
            end else begin
                write_register(CFG_GEOMETRY, cur.geometry);
                write_register(CFG_INV_RADIUS, cur.inv_radius);
                write_register(CFG_MAX_SPEED, cur.max_speed);
            end
            for (n = 0; n < cur.items; n++) begin
                send_command(rand_velocity(), rand_velocity(), rand_velocity(),
                             cur.gap_pct, 1'b0, ZERO_SPEEDS);
            end
        end

        // Drain, then watch for stray strobes
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_speeds.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_speeds.size()));
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Hang guard
    initial begin : watchdog
        #6000000;
        $display("simulation failed");
        $finish;
    end

endmodule
